// ----- src/cri_pkg.sv -----
// shared types and constants of the catmull-rom path interpolator
package cri_pkg;

  // width of one coordinate field on the streams
  localparam int DataBits   = 32;
  // basis weights: signed, 16 fraction bits, magnitude up to 1.0
  localparam int WeightFrac = 16;
  localparam int WeightBits = WeightFrac + 2;
  // waypoint count of the running path saturates here
  localparam int PtsMax     = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG_HEAD,
    ST_SEG_TAIL,
    ST_POINT,
    ST_ERROR,
    ST_COMMIT
  } cri_state_e;

  // what the datapath makes of one issued slot
  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_POINT,
    KIND_ZERO
  } cri_kind_e;

  typedef struct packed {
    logic      capture;      // latch the incoming waypoint
    logic      issue;        // push one result slot into the pipeline
    logic      commit;       // shift the waypoint into the history
    logic      tail_seg;     // final segment of the path (ends at the new point)
    logic      clamp_start;  // start of path: repeat the first point
    cri_kind_e kind;
  } cri_cmd_t;

  typedef struct packed {
    logic advance;           // pipeline moves this cycle
  } cri_stat_t;

endpackage

// ----- src/cri_ctrl.sv -----
// sequencer: walks the samples of each segment and drives the datapath
module cri_ctrl import cri_pkg::*; #(
  parameter int SAMPLES_PER_SEGMENT = 20,
  parameter int IdxBits             = $clog2(SAMPLES_PER_SEGMENT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  cri_stat_t          stat_i,
  output cri_cmd_t           cmd_o,
  output logic [IdxBits-1:0] idx_o
);

  localparam logic [IdxBits-1:0] IdxLast = IdxBits'(SAMPLES_PER_SEGMENT - 1);

  cri_state_e         state_q, state_d;
  logic [1:0]         pts_q, pts_d;
  logic [1:0]         seen_q, seen_d;
  logic               last_q, last_d;
  logic [IdxBits-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pts_q   <= '0;
      seen_q  <= '0;
      last_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      pts_q   <= pts_d;
      seen_q  <= seen_d;
      last_q  <= last_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pts_d      = pts_q;
    seen_d     = seen_q;
    last_d     = last_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = KIND_SAMPLE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          seen_d = pts_q;
          last_d = in_last_i;
          idx_d  = '0;
          if (pts_q == 2'd0 && in_last_i) begin
            pts_d   = '0;
            state_d = ST_ERROR;
          end else begin
            if (in_last_i) begin
              pts_d = '0;
            end else if (pts_q != 2'(PtsMax)) begin
              pts_d = pts_q + 2'd1;
            end
            if (pts_q >= 2'd2) begin
              state_d = ST_SEG_HEAD;
            end else if (in_last_i) begin
              state_d = ST_SEG_TAIL;
            end else begin
              state_d = ST_COMMIT;
            end
          end
        end
      end
      ST_SEG_HEAD: begin
        cmd_o.clamp_start = (seen_q == 2'd2);
        if (stat_i.advance) begin
          cmd_o.issue = 1'b1;
          if (idx_q == IdxLast) begin
            idx_d = '0;
            if (last_q) begin
              state_d = ST_SEG_TAIL;
            end else begin
              cmd_o.commit = 1'b1;
              state_d      = ST_IDLE;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_SEG_TAIL: begin
        cmd_o.tail_seg    = 1'b1;
        cmd_o.clamp_start = (seen_q == 2'd1);
        if (stat_i.advance) begin
          cmd_o.issue = 1'b1;
          if (idx_q == IdxLast) begin
            idx_d   = '0;
            state_d = ST_POINT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_POINT: begin
        cmd_o.tail_seg = 1'b1;
        cmd_o.kind     = KIND_POINT;
        if (stat_i.advance) begin
          cmd_o.issue  = 1'b1;
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_ERROR: begin
        cmd_o.kind = KIND_ZERO;
        if (stat_i.advance) begin
          cmd_o.issue = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idx_o = idx_q;

  a_issue_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> stat_i.advance)
    else $error("slot issued while the pipeline is stalled");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q != ST_IDLE)
    else $error("accepted waypoint started no work");

  a_error_resets_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERROR && stat_i.advance) |=> (state_q == ST_IDLE && pts_q == 2'd0))
    else $error("error result did not restart the path");

endmodule

// ----- src/cri_datapath.sv -----
// waypoint history, weight table and the multiply / sum / round pipeline
module cri_datapath import cri_pkg::*; #(
  parameter int SAMPLES_PER_SEGMENT = 20,
  parameter int COORD_WIDTH         = 32,
  parameter int IdxBits             = $clog2(SAMPLES_PER_SEGMENT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [2*DataBits-1:0] in_data_i,
  input  cri_cmd_t              cmd_i,
  input  logic [IdxBits-1:0]    idx_i,
  output cri_stat_t             stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2*DataBits-1:0] out_data_o,
  output logic                  out_eop_o,
  output logic                  out_err_o
);

  localparam int CoordBits = (COORD_WIDTH < DataBits) ? COORD_WIDTH : DataBits;
  localparam int ProdBits  = WeightBits + CoordBits;
  localparam int PairBits  = ProdBits + 1;
  localparam int SumBits   = ProdBits + 2;
  localparam int ShBits    = SumBits - WeightFrac;
  localparam longint Den   = 2 * SAMPLES_PER_SEGMENT * SAMPLES_PER_SEGMENT *
                             SAMPLES_PER_SEGMENT;
  localparam logic signed [SumBits-1:0]    RoundBias = SumBits'(1) <<< (WeightFrac - 1);
  localparam logic signed [WeightBits-1:0] WeightOne = WeightBits'(1) <<< WeightFrac;
  localparam logic signed [ShBits-1:0] SatHi =
    {{(ShBits - CoordBits + 1){1'b0}}, {(CoordBits - 1){1'b1}}};
  localparam logic signed [ShBits-1:0] SatLo =
    {{(ShBits - CoordBits + 1){1'b1}}, {(CoordBits - 1){1'b0}}};

  // half the cubic basis at t = j/S, rounded half away from zero
  function automatic logic signed [WeightBits-1:0] calc_weight(input int which,
                                                               input longint j);
    longint s;
    longint a;
    longint mag;
    longint q;
    s = longint'(SAMPLES_PER_SEGMENT);
    unique case (which)
      0:       a = -j*j*j + 2*j*j*s - j*s*s;
      1:       a = 3*j*j*j - 5*j*j*s + 2*s*s*s;
      2:       a = -3*j*j*j + 4*j*j*s + j*s*s;
      default: a = j*j*j - j*j*s;
    endcase
    mag = (a < 0) ? -a : a;
    q   = (mag * (longint'(1) <<< WeightFrac) + Den / 2) / Den;
    return WeightBits'((a < 0) ? -q : q);
  endfunction

  logic signed [WeightBits-1:0] weight_tbl [SAMPLES_PER_SEGMENT][4];

  for (genvar gj = 0; gj < SAMPLES_PER_SEGMENT; gj++) begin : g_row
    for (genvar gk = 0; gk < 4; gk++) begin : g_col
      assign weight_tbl[gj][gk] = calc_weight(gk, gj);
    end
  end

  // coordinate index 0 is x, 1 is y
  logic signed [CoordBits-1:0]  cur_q  [2];
  logic signed [CoordBits-1:0]  hist_q [2][3];
  logic signed [CoordBits-1:0]  opnd   [2][4];
  logic signed [WeightBits-1:0] wgt    [4];

  logic                         advance;
  logic                         v1_q, v2_q, out_valid_q;
  logic                         eop1_q, err1_q, eop2_q, err2_q, eop_q, err_q;
  logic signed [ProdBits-1:0]   prod_q [2][4];
  logic signed [PairBits-1:0]   pair_q [2][2];
  logic signed [SumBits-1:0]    sum_d  [2];
  logic signed [ShBits-1:0]     shr_d  [2];
  logic signed [CoordBits-1:0]  clip_d [2];
  logic signed [DataBits-1:0]   out_q  [2];

  // the whole pipeline steps together whenever the output slot frees up
  assign advance        = !out_valid_q || out_ready_i;
  assign stat_o.advance = advance;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_q[0] <= in_data_i[CoordBits-1:0];
      cur_q[1] <= in_data_i[DataBits+CoordBits-1:DataBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int e = 0; e < 3; e++) begin
          hist_q[c][e] <= '0;
        end
      end
    end else if (cmd_i.commit) begin
      for (int c = 0; c < 2; c++) begin
        hist_q[c][2] <= hist_q[c][1];
        hist_q[c][1] <= hist_q[c][0];
        hist_q[c][0] <= cur_q[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (cmd_i.tail_seg) begin
        opnd[c][0] = cmd_i.clamp_start ? hist_q[c][0] : hist_q[c][1];
        opnd[c][1] = hist_q[c][0];
        opnd[c][2] = cur_q[c];
        opnd[c][3] = cur_q[c];
      end else begin
        opnd[c][0] = cmd_i.clamp_start ? hist_q[c][1] : hist_q[c][2];
        opnd[c][1] = hist_q[c][1];
        opnd[c][2] = hist_q[c][0];
        opnd[c][3] = cur_q[c];
      end
    end
  end

  // the final point passes through as 1.0 times itself
  always_comb begin
    unique case (cmd_i.kind)
      KIND_SAMPLE: begin
        for (int k = 0; k < 4; k++) begin
          wgt[k] = weight_tbl[idx_i][k];
        end
      end
      KIND_POINT: begin
        wgt[0] = '0;
        wgt[1] = '0;
        wgt[2] = WeightOne;
        wgt[3] = '0;
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          wgt[k] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sum_d[c]  = SumBits'(pair_q[c][0]) + SumBits'(pair_q[c][1]) + RoundBias;
      shr_d[c]  = sum_d[c][SumBits-1:WeightFrac];
      if (shr_d[c] > SatHi) begin
        clip_d[c] = SatHi[CoordBits-1:0];
      end else if (shr_d[c] < SatLo) begin
        clip_d[c] = SatLo[CoordBits-1:0];
      end else begin
        clip_d[c] = shr_d[c][CoordBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      eop1_q <= (cmd_i.kind != KIND_SAMPLE);
      err1_q <= (cmd_i.kind == KIND_ZERO);
      eop2_q <= eop1_q;
      err2_q <= err1_q;
      eop_q  <= eop2_q;
      err_q  <= err2_q;
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod_q[c][k] <= opnd[c][k] * wgt[k];
        end
        pair_q[c][0] <= PairBits'(prod_q[c][0]) + PairBits'(prod_q[c][1]);
        pair_q[c][1] <= PairBits'(prod_q[c][2]) + PairBits'(prod_q[c][3]);
        out_q[c]     <= DataBits'(clip_d[c]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_q[1], out_q[0]};
  assign out_eop_o   = eop_q;
  assign out_err_o   = err_q;

  a_err_ends_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> eop_q)
    else $error("error result not marked as end of path");

  a_err_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (out_q[0] == '0 && out_q[1] == '0))
    else $error("error result carries a nonzero point");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_o)))
    else $error("stalled result changed before its transfer");

endmodule

// ----- src/catmull_rom_path_interpolator_core.sv -----
// top level of the uniform catmull-rom path interpolator
//
// takes 2-d waypoints in signed q16.16 and emits SAMPLES_PER_SEGMENT evenly
// spaced catmull-rom samples per segment, with the path ends clamped by
// repeating the first and last waypoint. from the third waypoint of a path on,
// each waypoint produces the samples of the segment two points back; the
// waypoint flagged with tlast also produces the closing segment and then itself
// with m_axis_tlast_o set. a path whose first waypoint already carries tlast
// yields one zero point with tlast and tuser set. only the low COORD_WIDTH bits
// (at most 32) of each coordinate are used, and results saturate to that range.
// a waypoint is taken when the sequencer is idle, and the sequencer takes no
// new waypoint until it has issued every result of the last one and is idle
// again. the single multiply-sum-round pipeline takes one result slot per
// cycle while the output is not stalled; each result passes through the
// product, pair-sum and rounded output registers. back-pressure on the output
// stalls the pipeline and the sequencer with it.
module catmull_rom_path_interpolator_core import cri_pkg::*; #(
  parameter int SAMPLES_PER_SEGMENT = 20,
  parameter int COORD_WIDTH         = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // waypoint stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [2*DataBits-1:0] s_axis_tdata_i,  // [31:0] waypoint_x, [63:32] waypoint_y
  input  logic                  s_axis_tlast_i,  // is_last
  // sample stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [2*DataBits-1:0] m_axis_tdata_o,  // [31:0] point_x, [63:32] point_y
  output logic                  m_axis_tlast_o,  // end_of_path
  output logic                  m_axis_tuser_o   // too_few_points
);

  localparam int IdxBits = $clog2(SAMPLES_PER_SEGMENT);

  cri_cmd_t           cmd;
  cri_stat_t          stat;
  logic [IdxBits-1:0] sample_idx;

  // sequencer: decides per waypoint which segments and points to emit
  cri_ctrl #(
    .SAMPLES_PER_SEGMENT(SAMPLES_PER_SEGMENT),
    .IdxBits            (IdxBits)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_last_i (s_axis_tlast_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .idx_o     (sample_idx)
  );

  // datapath: history, weight table, multipliers and the output register
  cri_datapath #(
    .SAMPLES_PER_SEGMENT(SAMPLES_PER_SEGMENT),
    .COORD_WIDTH        (COORD_WIDTH),
    .IdxBits            (IdxBits)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .idx_i      (sample_idx),
    .stat_o     (stat),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .out_eop_o  (m_axis_tlast_o),
    .out_err_o  (m_axis_tuser_o)
  );

endmodule
